@@ rtl/assert_macros.svh @@
// assertion macros shared by the encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define PB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define PB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/pbrle_pkg.sv @@
// shared constants and types of the packbits encoder
package pbrle_pkg;

    localparam int MAX_RUN     = 128;
    localparam int MAX_LITERAL = 128;
    localparam int LANE_BYTES  = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W      = 8;
    localparam int OUT_WORD_W  = 32;
    localparam int OUT_CNT_W   = 3;
    localparam int WORD_W      = LANE_BYTES * BYTE_W;
    localparam int LANE_CNT_W  = $clog2(LANE_BYTES + 1);
    localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
    localparam int LIT_IDX_W   = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
    localparam int RAM_ADDR_W  = LIT_IDX_W + 1;
    localparam int RAM_DEPTH   = 2 ** RAM_ADDR_W;

    // one packet: control byte, then n_st bytes from the literal bank, then tail bytes
    typedef struct packed {
        logic [BYTE_W-1:0]    ctrl;
        logic [LIT_IDX_W-1:0] n_st;
        logic                 bank;
        logic [1:0]           n_tail;
        logic [BYTE_W-1:0]    tail0;
        logic [BYTE_W-1:0]    tail1;
        logic                 item_last;
        logic                 stream_end;
    } t_cmd;

    typedef struct packed {
        logic push0;
        logic push1;
        t_cmd cmd0;
        t_cmd cmd1;
    } t_qpush;

    typedef struct packed {
        logic                  en;
        logic [RAM_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     data;
    } t_wr;

    typedef struct packed {
        logic                  en;
        logic [RAM_ADDR_W-1:0] addr;
    } t_rd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

endpackage

@@ rtl/pbrle_ram.sv @@
// generic single-write single-read ram with registered read data
module pbrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pbrle_front.sv @@
// front end: run/literal tracking, literal store writes, packet commands
`include "assert_macros.svh"

module pbrle_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pbrle_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_stream_end,
    input  logic                        i_q_room,
    output pbrle_pkg::t_qpush           o_push,
    output pbrle_pkg::t_wr              o_wr,
    input  pbrle_pkg::t_rel             i_rel
);
    import pbrle_pkg::*;

    logic [RUN_CNT_W-1:0] r_rc, n_rc;
    logic [BYTE_W-1:0]    r_rv, n_rv;
    logic [LIT_IDX_W-1:0] r_lc, n_lc;
    logic                 r_bank;
    logic [1:0]           r_busy, n_busy;

    logic                 accept;
    logic                 same;
    logic                 full;
    logic                 lit_open;
    logic                 run_max;
    logic [RUN_CNT_W-1:0] rc_inc;
    logic                 flush_store;
    logic                 v0, v1;
    t_cmd                 c0, c1;
    t_wr                  wr;

    function automatic t_cmd mk_lit(input logic [LIT_IDX_W-1:0] n_st,
                                    input logic [1:0] n_tail,
                                    input logic [BYTE_W-1:0] t0,
                                    input logic [BYTE_W-1:0] t1,
                                    input logic bank);
        t_cmd       c;
        logic [8:0] s;
        s           = 9'(n_st) + 9'(n_tail) - 9'd1;
        c           = '0;
        c.ctrl      = s[7:0];
        c.n_st      = n_st;
        c.bank      = bank;
        c.n_tail    = n_tail;
        c.tail0     = t0;
        c.tail1     = t1;
        return c;
    endfunction

    function automatic t_cmd mk_run(input logic [RUN_CNT_W-1:0] cnt,
                                    input logic [BYTE_W-1:0] value);
        t_cmd       c;
        logic [8:0] s;
        s        = 9'd1 - 9'(cnt);
        c        = '0;
        c.ctrl   = s[7:0];
        c.n_tail = 2'd1;
        c.tail0  = value;
        return c;
    endfunction

    assign o_in_stall = !i_rst_n || r_busy[r_bank] || !i_q_room;
    assign accept     = i_in_valid && !o_in_stall;

    assign same     = (r_rc != '0) && (i_in_byte == r_rv);
    assign full     = (r_lc == LIT_IDX_W'(MAX_LITERAL - 1));
    assign lit_open = (r_lc != '0);
    assign rc_inc   = r_rc + RUN_CNT_W'(1);
    assign run_max  = (rc_inc == RUN_CNT_W'(MAX_RUN));

    always_comb begin
        n_rc        = r_rc;
        n_rv        = r_rv;
        n_lc        = r_lc;
        v0          = 1'b0;
        v1          = 1'b0;
        c0          = '0;
        c1          = '0;
        wr          = '0;
        flush_store = 1'b0;

        if (!i_stream_end) begin
            if (r_rc == '0) begin
                n_rv = i_in_byte;
                n_rc = RUN_CNT_W'(1);
            end else if (same) begin
                if (r_rc == RUN_CNT_W'(1) && lit_open) begin
                    c0          = mk_lit(r_lc, 2'd0, '0, '0, r_bank);
                    v0          = 1'b1;
                    flush_store = 1'b1;
                    n_lc        = '0;
                end
                if (run_max) begin
                    if (v0) begin
                        c1 = mk_run(rc_inc, r_rv);
                        v1 = 1'b1;
                    end else begin
                        c0 = mk_run(rc_inc, r_rv);
                        v0 = 1'b1;
                    end
                    n_rc = '0;
                end else begin
                    n_rc = rc_inc;
                end
            end else begin
                if (r_rc > RUN_CNT_W'(1)) begin
                    c0 = mk_run(r_rc, r_rv);
                    v0 = 1'b1;
                end else if (full) begin
                    // the held byte fills the literal: store bytes plus it as tail
                    c0          = mk_lit(r_lc, 2'd1, r_rv, '0, r_bank);
                    v0          = 1'b1;
                    flush_store = lit_open;
                    n_lc        = '0;
                end else begin
                    wr.en   = 1'b1;
                    wr.addr = {r_bank, r_lc};
                    wr.data = r_rv;
                    n_lc    = r_lc + LIT_IDX_W'(1);
                end
                n_rv = i_in_byte;
                n_rc = RUN_CNT_W'(1);
            end
        end else begin
            // end of stream: everything pending goes out in at most two packets
            if (r_rc == '0) begin
                c0          = mk_lit(r_lc, 2'd1, i_in_byte, '0, r_bank);
                v0          = 1'b1;
                flush_store = lit_open;
            end else if (same) begin
                if (r_rc == RUN_CNT_W'(1) && lit_open) begin
                    c0          = mk_lit(r_lc, 2'd0, '0, '0, r_bank);
                    c1          = mk_run(rc_inc, r_rv);
                    v0          = 1'b1;
                    v1          = 1'b1;
                    flush_store = 1'b1;
                end else begin
                    c0 = mk_run(rc_inc, r_rv);
                    v0 = 1'b1;
                end
            end else if (r_rc > RUN_CNT_W'(1)) begin
                c0 = mk_run(r_rc, r_rv);
                c1 = mk_lit('0, 2'd1, i_in_byte, '0, r_bank);
                v0 = 1'b1;
                v1 = 1'b1;
            end else if (full) begin
                c0          = mk_lit(r_lc, 2'd1, r_rv, '0, r_bank);
                c1          = mk_lit('0, 2'd1, i_in_byte, '0, r_bank);
                v0          = 1'b1;
                v1          = 1'b1;
                flush_store = lit_open;
            end else begin
                c0          = mk_lit(r_lc, 2'd2, r_rv, i_in_byte, r_bank);
                v0          = 1'b1;
                flush_store = lit_open;
            end
            n_rc = '0;
            n_rv = '0;
            n_lc = '0;
        end

        // the last packet of the item carries the item mark; every packet carries the stream mark
        c0.stream_end = i_stream_end;
        c1.stream_end = i_stream_end;
        if (v1) begin
            c1.item_last = 1'b1;
        end else if (v0) begin
            c0.item_last = 1'b1;
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (accept && flush_store) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc   <= '0;
            r_rv   <= '0;
            r_lc   <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                r_rc <= n_rc;
                r_rv <= n_rv;
                r_lc <= n_lc;
                if (flush_store) begin
                    r_bank <= ~r_bank;
                end
            end
        end
    end

    assign o_push.push0 = accept && v0;
    assign o_push.push1 = accept && v1;
    assign o_push.cmd0  = c0;
    assign o_push.cmd1  = c1;

    assign o_wr.en   = accept && wr.en;
    assign o_wr.addr = wr.addr;
    assign o_wr.data = wr.data;

    `PB_ASSERT_NOW(a_rel_of_busy_bank, i_clk, i_rst_n, i_rel.valid, r_busy[i_rel.bank])
    `PB_ASSERT_NOW(a_open_lit_bank_free, i_clk, i_rst_n, r_lc != '0, !r_busy[r_bank])

endmodule

@@ rtl/pbrle_queue.sv @@
// command queue between front and back, takes up to two packets a cycle
`include "assert_macros.svh"

module pbrle_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbrle_pkg::t_qpush   i_push,
    output logic                o_room2,
    output logic                o_valid,
    output pbrle_pkg::t_cmd     o_head,
    input  logic                i_pop
);
    import pbrle_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;
    logic [CNT_W-1:0] n_count;

    assign pop     = i_pop && (r_count != '0);
    assign n_count = r_count + CNT_W'(i_push.push0) + CNT_W'(i_push.push1) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wptr] <= i_push.cmd0;
        end
        if (i_push.push1) begin
            r_mem[r_wptr + PTR_W'(1)] <= i_push.cmd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(i_push.push0) + PTR_W'(i_push.push1);
            r_rptr  <= r_rptr + PTR_W'(pop);
            r_count <= n_count;
        end
    end

    assign o_room2 = (r_count <= CNT_W'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    `PB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `PB_ASSERT_NOW(a_push_order, i_clk, i_rst_n, i_push.push1, i_push.push0)

endmodule

@@ rtl/pbrle_back.sv @@
// back end: walks packets byte by byte and packs bytes into result words
`include "assert_macros.svh"

module pbrle_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  pbrle_pkg::t_cmd                 i_q_head,
    output logic                            o_q_pop,
    output pbrle_pkg::t_rd                  o_rd,
    input  logic [pbrle_pkg::BYTE_W-1:0]    i_rdata,
    output pbrle_pkg::t_rel                 o_rel,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pbrle_pkg::OUT_WORD_W-1:0] o_out_word,
    output logic [pbrle_pkg::OUT_CNT_W-1:0] o_byte_count,
    output logic                            o_burst_last,
    output logic                            o_stream_last
);
    import pbrle_pkg::*;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_STORE,
        PH_TAIL
    } t_phase;

    // sequencer
    logic                  r_busy;
    t_cmd                  r_cmd;
    t_phase                r_phase, n_phase;
    logic [LIT_IDX_W-1:0]  r_idx;
    logic                  r_tidx;
    // byte stage, lines up with the ram read latency
    logic                  r_b_valid;
    logic                  r_b_ram;
    logic [BYTE_W-1:0]     r_b_imm;
    logic                  r_b_last;
    logic                  r_b_end;
    // packer
    logic [WORD_W-1:0]     r_asm_word;
    logic [LANE_CNT_W-1:0] r_asm_cnt;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_word;
    logic [LANE_CNT_W-1:0] r_out_cnt;
    logic                  r_out_burst;
    logic                  r_out_stream;
    // bank release
    logic                  r_rel_valid;
    logic                  r_rel_bank;

    logic                  pack_ok;
    logic                  b_take;
    logic                  a_ok;
    logic                  issue;
    logic                  load;
    logic                  has_st;
    logic                  has_tail;
    logic                  st_last;
    logic                  tail_last;
    logic                  cmd_end;
    logic                  slot_ram;
    logic [BYTE_W-1:0]     slot_imm;
    logic [BYTE_W-1:0]     b_byte;
    logic [WORD_W-1:0]     word_n;
    logic [LANE_CNT_W-1:0] cnt_n;
    logic                  word_done;

    assign pack_ok = !r_out_valid || !i_out_stall;
    assign b_take  = r_b_valid && pack_ok;
    assign a_ok    = !r_b_valid || b_take;
    assign issue   = r_busy && a_ok;

    assign has_st    = (r_cmd.n_st != '0);
    assign has_tail  = (r_cmd.n_tail != 2'd0);
    assign st_last   = (r_idx == (r_cmd.n_st - LIT_IDX_W'(1)));
    assign tail_last = (({1'b0, r_tidx} + 2'd1) == r_cmd.n_tail);

    always_comb begin
        cmd_end  = 1'b0;
        slot_ram = 1'b0;
        slot_imm = r_cmd.ctrl;
        n_phase  = r_phase;
        unique case (r_phase)
            PH_CTRL: begin
                cmd_end = !has_st && !has_tail;
                if (has_st) begin
                    n_phase = PH_STORE;
                end else if (has_tail) begin
                    n_phase = PH_TAIL;
                end
            end
            PH_STORE: begin
                slot_ram = 1'b1;
                cmd_end  = st_last && !has_tail;
                if (st_last) begin
                    n_phase = has_tail ? PH_TAIL : PH_CTRL;
                end
            end
            PH_TAIL: begin
                slot_imm = r_tidx ? r_cmd.tail1 : r_cmd.tail0;
                cmd_end  = tail_last;
                if (tail_last) begin
                    n_phase = PH_CTRL;
                end
            end
            default: begin
                n_phase = PH_CTRL;
            end
        endcase
    end

    assign load    = (!r_busy || (issue && cmd_end)) && i_q_valid;
    assign o_q_pop = load;

    assign o_rd.en   = issue && slot_ram;
    assign o_rd.addr = {r_cmd.bank, r_idx};

    // packer input
    assign b_byte    = r_b_ram ? i_rdata : r_b_imm;
    assign word_n    = r_asm_word | (WORD_W'(b_byte) << {r_asm_cnt, 3'b000});
    assign cnt_n     = r_asm_cnt + LANE_CNT_W'(1);
    assign word_done = (cnt_n == LANE_CNT_W'(LANE_BYTES)) || r_b_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_CTRL;
            r_idx       <= '0;
            r_tidx      <= 1'b0;
            r_b_valid   <= 1'b0;
            r_asm_word  <= '0;
            r_asm_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_rel_valid <= 1'b0;
            r_rel_bank  <= 1'b0;
        end else begin
            if (load) begin
                r_cmd  <= i_q_head;
                r_busy <= 1'b1;
            end else if (issue && cmd_end) begin
                r_busy <= 1'b0;
            end

            if (issue) begin
                r_phase <= n_phase;
                r_idx   <= (r_phase == PH_STORE && !st_last) ? r_idx + LIT_IDX_W'(1) : '0;
                r_tidx  <= (r_phase == PH_TAIL && !tail_last);
            end

            if (a_ok) begin
                r_b_valid <= issue;
                if (issue) begin
                    r_b_ram  <= slot_ram;
                    r_b_imm  <= slot_imm;
                    r_b_last <= cmd_end && r_cmd.item_last;
                    r_b_end  <= r_cmd.stream_end;
                end
            end

            // last store read has been taken by the ram, the bank may be refilled
            r_rel_valid <= issue && (r_phase == PH_STORE) && st_last;
            r_rel_bank  <= r_cmd.bank;

            if (b_take) begin
                if (word_done) begin
                    r_asm_word <= '0;
                    r_asm_cnt  <= '0;
                end else begin
                    r_asm_word <= word_n;
                    r_asm_cnt  <= cnt_n;
                end
            end

            if (b_take && word_done) begin
                r_out_valid  <= 1'b1;
                r_out_word   <= word_n;
                r_out_cnt    <= cnt_n;
                r_out_burst  <= r_b_last;
                r_out_stream <= r_b_last && r_b_end;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rel.valid = r_rel_valid;
    assign o_rel.bank  = r_rel_bank;

    assign o_out_valid   = r_out_valid;
    assign o_out_word    = OUT_WORD_W'(r_out_word);
    assign o_byte_count  = OUT_CNT_W'(r_out_cnt);
    assign o_burst_last  = r_out_burst;
    assign o_stream_last = r_out_stream;

    `PB_ASSERT_NOW(a_out_cnt_range, i_clk, i_rst_n, r_out_valid,
                   r_out_cnt != '0 && r_out_cnt <= LANE_CNT_W'(LANE_BYTES))

endmodule

@@ rtl/packbits_rle_encoder.sv @@
// top level of the streaming packbits run-length encoder
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_in_byte, i_stream_end
//  result    out        o_out_valid / i_out_stall  o_out_word, o_byte_count,
//                                                  o_burst_last, o_stream_last
//
// rate: the front takes one item per cycle while o_in_stall is low; the back walks one
//   compressed byte per cycle (control, literal and tail bytes alike) while the output is
//   not stalled, so the throughput is set by that byte-serial walk
// a literal packet is read from its ram bank while the other bank fills; the front
//   holds off while its current bank is still being drained or the queue is short
// reset: synchronous, active low, clears control state; the literal ram is not cleared
// stalls: an output stall holds the result word and stops the back; the front keeps
//   taking items until the command queue has fewer than two free slots or its current
//   bank is still being drained, then raises o_in_stall
module packbits_rle_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [pbrle_pkg::BYTE_W-1:0]     i_in_byte,
    input  logic                             i_stream_end,
    // result items
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [pbrle_pkg::OUT_WORD_W-1:0] o_out_word,
    output logic [pbrle_pkg::OUT_CNT_W-1:0]  o_byte_count,
    output logic                             o_burst_last,
    output logic                             o_stream_last
);
    import pbrle_pkg::*;

    // front to queue
    t_qpush            push;
    logic              q_room2;
    // queue to back
    logic              q_valid;
    t_cmd              q_head;
    logic              q_pop;
    // literal ram ports
    t_wr               wr;
    t_rd               rd;
    logic [BYTE_W-1:0] rdata;
    // back tells the front when a literal bank is free again
    t_rel              rel;

    // classifies each byte, keeps the pending run and open literal
    pbrle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_stream_end (i_stream_end),
        .i_q_room     (q_room2),
        .o_push       (push),
        .o_wr         (wr),
        .i_rel        (rel)
    );

    // short packet queue decoupling front and back
    pbrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (q_room2),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    // two literal banks, bank select in the top address bit
    pbrle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (rdata)
    );

    // expands packets into bytes and packs result words
    pbrle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_rd          (rd),
        .i_rdata       (rdata),
        .o_rel         (rel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .o_byte_count  (o_byte_count),
        .o_burst_last  (o_burst_last),
        .o_stream_last (o_stream_last)
    );

endmodule
